>>> rtl/core/stable_merge_sort_records_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stable merge sort block
// Immediate-implication and next-cycle checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef STABLE_MERGE_SORT_RECORDS_DEFINES_SVH
`define STABLE_MERGE_SORT_RECORDS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that cond implies prop in the same cycle
`define SMSR_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("smsr check failed");

// Check that cond implies prop in the following cycle
`define SMSR_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("smsr check failed");

`else

`define SMSR_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define SMSR_ASSERT_NXT(label, clk, rst_n, cond, prop)

`endif

`endif

>>> rtl/core/smsr_pkg.sv
// ----------------------------------------------------------------------------
// smsr_pkg
// Field widths, sequencer states and run phases of the merge sort block.
// ----------------------------------------------------------------------------
package smsr_pkg;

    // Record field widths
    localparam int KEY_W = 12;
    localparam int TAG_W = 32;
    localparam int REC_W = KEY_W + TAG_W;
    localparam int CMP_W = 9;

    // Comparison counter saturates here
    localparam logic [CMP_W-1:0] CMP_SAT = '1;

    // Sequencer states
    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_WALK  = 9'b000000010,
        S_MRD   = 9'b000000100,
        S_MCMP  = 9'b000001000,
        S_CRD   = 9'b000010000,
        S_CWR   = 9'b000100000,
        S_ORD   = 9'b001000000,
        S_OLD   = 9'b010000000,
        S_OWAIT = 9'b100000000
    } state_t;

    // Progress of one run on the split stack
    typedef enum logic [1:0] {
        PH_LEFT  = 2'd0,
        PH_RIGHT = 2'd1,
        PH_MERGE = 2'd2
    } phase_t;

endpackage

>>> rtl/core/stable_merge_sort_records.sv
// ----------------------------------------------------------------------------
// stable_merge_sort_records
// Collects records until one marked last, sorts them stably by key with
// top-down merge sort (midpoint splits), then streams them out in order.
// ----------------------------------------------------------------------------
//
//  channel  signals                                         direction
//  -------  ----------------------------------------------  ---------
//  in       in_valid/in_ready, sort_key, record_tag,         sink
//           is_last
//  out      out_valid/out_ready, sorted_key, sorted_tag,     source
//           last_out, compare_count, overflowed
//
//  Loading accepts one request per cycle. After the last request, each merge
//  reads and compares the two run heads and writes the smaller into the merge
//  buffer, record by record, then copies the merged run back into the store,
//  paced by the single store write port and the one key comparator. Each result
//  is read from the store, registered and then held until out_ready takes it.
//  Reset clears the sequencer and counters; stores need no clearing. in_ready
//  is low from the last request until the final result is taken.
//
`include "stable_merge_sort_records_defines.svh"

module stable_merge_sort_records #(
    parameter int MAX_RECORDS = 64,
    parameter int KEY_BITS    = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [smsr_pkg::KEY_W-1:0] sort_key,
    input  logic [smsr_pkg::TAG_W-1:0] record_tag,
    input  logic                       is_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [smsr_pkg::KEY_W-1:0] sorted_key,
    output logic [smsr_pkg::TAG_W-1:0] sorted_tag,
    output logic                       last_out,
    output logic [smsr_pkg::CMP_W-1:0] compare_count,
    output logic                       overflowed
);

    import smsr_pkg::*;

    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int IDX_W  = $clog2(MAX_RECORDS);
    localparam int STK_D  = $clog2(MAX_RECORDS) + 1;
    localparam int STK_IW = $clog2(STK_D);
    localparam int SP_W   = $clog2(STK_D + 1);
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((64'(1) << KEY_BITS) - 64'(1));
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);

    // Storage
    logic [REC_W-1:0] record_store [MAX_RECORDS];
    logic [REC_W-1:0] merge_buffer [MAX_RECORDS];
    logic [IDX_W-1:0] stk_lo_reg   [STK_D];
    logic [IDX_W-1:0] stk_hi_reg   [STK_D];
    phase_t           stk_ph_reg   [STK_D];

    // Control registers
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CMP_W-1:0] cmp_reg, cmp_next;
    logic             ovf_reg, ovf_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic             out_valid_reg, out_valid_next;

    // Datapath registers
    logic [CNT_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [REC_W-1:0] rd_a_reg, rd_b_reg, buf_rd_reg;
    logic [KEY_W-1:0] out_key_reg, out_key_next;
    logic [TAG_W-1:0] out_tag_reg, out_tag_next;
    logic             out_last_reg, out_last_next;
    logic [CMP_W-1:0] out_cmp_reg, out_cmp_next;
    logic             out_ovf_reg, out_ovf_next;

    // Memory and stack port controls
    logic             st_we;
    logic [IDX_W-1:0] st_waddr;
    logic [REC_W-1:0] st_wdata;
    logic [IDX_W-1:0] st_raddr_a, st_raddr_b;
    logic             buf_we;
    logic [IDX_W-1:0] buf_waddr;
    logic [REC_W-1:0] buf_wdata;
    logic             push_en;
    logic [IDX_W-1:0] push_lo, push_hi;
    logic             ph_we;
    phase_t           ph_val;

    // Top of stack
    logic [SP_W-1:0]   sp_dec;
    logic [STK_IW-1:0] top_idx, push_idx;
    logic [IDX_W-1:0]  top_lo, top_hi, top_mid;
    phase_t            top_ph;

    // Merge compare
    logic             a_ok, b_ok, take_a;
    logic [CNT_W-1:0] n_last;

    assign sp_dec   = sp_reg - SP_W'(1);
    assign top_idx  = sp_dec[STK_IW-1:0];
    assign push_idx = sp_reg[STK_IW-1:0];
    assign top_lo   = stk_lo_reg[top_idx];
    assign top_hi   = stk_hi_reg[top_idx];
    assign top_ph   = stk_ph_reg[top_idx];
    assign top_mid  = top_lo + ((top_hi - top_lo) >> 1);

    assign a_ok   = (a_reg <= mid_reg);
    assign b_ok   = (b_reg <= hi_reg);
    assign take_a = a_ok && (!b_ok ||
                    (rd_a_reg[REC_W-1 -: KEY_W] <= rd_b_reg[REC_W-1 -: KEY_W]));
    assign n_last = (count_reg < CNT_MAX) ? (count_reg + CNT_W'(1)) : count_reg;

    assign in_ready      = (state_reg == S_LOAD);
    assign out_valid     = out_valid_reg;
    assign sorted_key    = out_key_reg;
    assign sorted_tag    = out_tag_reg;
    assign last_out      = out_last_reg;
    assign compare_count = out_cmp_reg;
    assign overflowed    = out_ovf_reg;

    // Sequence load, split walk, merge, copy back and emit
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmp_next       = cmp_reg;
        ovf_next       = ovf_reg;
        sp_next        = sp_reg;
        out_valid_next = out_valid_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        out_key_next   = out_key_reg;
        out_tag_next   = out_tag_reg;
        out_last_next  = out_last_reg;
        out_cmp_next   = out_cmp_reg;
        out_ovf_next   = out_ovf_reg;
        st_we          = 1'b0;
        st_waddr       = count_reg[IDX_W-1:0];
        st_wdata       = {sort_key & KEY_MASK, record_tag};
        st_raddr_a     = a_reg[IDX_W-1:0];
        st_raddr_b     = b_reg[IDX_W-1:0];
        buf_we         = 1'b0;
        buf_waddr      = k_reg[IDX_W-1:0];
        buf_wdata      = take_a ? rd_a_reg : rd_b_reg;
        push_en        = 1'b0;
        push_lo        = top_lo;
        push_hi        = top_mid;
        ph_we          = 1'b0;
        ph_val         = PH_RIGHT;

        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    // Store the request, or drop it when full
                    if (count_reg < CNT_MAX)
                    begin
                        st_we      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    // Seed the split stack with the whole set
                    if (is_last)
                    begin
                        push_en    = 1'b1;
                        push_lo    = '0;
                        push_hi    = IDX_W'(n_last - CNT_W'(1));
                        sp_next    = SP_W'(1);
                        cmp_next   = '0;
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                if (sp_reg == '0)
                begin
                    k_next     = '0;
                    state_next = S_ORD;
                end
                else if (top_lo >= top_hi)
                begin
                    sp_next = sp_dec;
                end
                else
                begin
                    case (top_ph)
                        PH_LEFT:
                        begin
                            // Descend into the left half
                            ph_we   = 1'b1;
                            ph_val  = PH_RIGHT;
                            push_en = 1'b1;
                            push_lo = top_lo;
                            push_hi = top_mid;
                            sp_next = sp_reg + SP_W'(1);
                        end
                        PH_RIGHT:
                        begin
                            // Descend into the right half
                            ph_we   = 1'b1;
                            ph_val  = PH_MERGE;
                            push_en = 1'b1;
                            push_lo = top_mid + IDX_W'(1);
                            push_hi = top_hi;
                            sp_next = sp_reg + SP_W'(1);
                        end
                        default:
                        begin
                            // Both halves sorted: start the merge
                            a_next     = CNT_W'(top_lo);
                            b_next     = CNT_W'(top_mid) + CNT_W'(1);
                            k_next     = CNT_W'(top_lo);
                            lo_next    = CNT_W'(top_lo);
                            mid_next   = CNT_W'(top_mid);
                            hi_next    = CNT_W'(top_hi);
                            state_next = S_MRD;
                        end
                    endcase
                end
            end

            S_MRD:
            begin
                state_next = S_MCMP;
            end

            S_MCMP:
            begin
                // Take the smaller head, left on ties
                buf_we = 1'b1;
                if (a_ok && b_ok && (cmp_reg != CMP_SAT))
                begin
                    cmp_next = cmp_reg + CMP_W'(1);
                end
                if (take_a)
                begin
                    a_next = a_reg + CNT_W'(1);
                end
                else
                begin
                    b_next = b_reg + CNT_W'(1);
                end
                if (k_reg == hi_reg)
                begin
                    k_next     = lo_reg;
                    state_next = S_CRD;
                end
                else
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_MRD;
                end
            end

            S_CRD:
            begin
                state_next = S_CWR;
            end

            S_CWR:
            begin
                // Copy the merged run back into the store
                st_we    = 1'b1;
                st_waddr = k_reg[IDX_W-1:0];
                st_wdata = buf_rd_reg;
                if (k_reg == hi_reg)
                begin
                    sp_next    = sp_dec;
                    state_next = S_WALK;
                end
                else
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_CRD;
                end
            end

            S_ORD:
            begin
                st_raddr_a = k_reg[IDX_W-1:0];
                state_next = S_OLD;
            end

            S_OLD:
            begin
                // Present the next sorted record
                out_key_next   = rd_a_reg[REC_W-1 -: KEY_W];
                out_tag_next   = rd_a_reg[TAG_W-1:0];
                out_last_next  = ((k_reg + CNT_W'(1)) == count_reg);
                out_cmp_next   = ((k_reg + CNT_W'(1)) == count_reg) ? cmp_reg : '0;
                out_ovf_next   = ovf_reg;
                out_valid_next = 1'b1;
                state_next     = S_OWAIT;
            end

            S_OWAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        // Set done: clear for the next one
                        count_next = '0;
                        cmp_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = S_ORD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            cmp_reg       <= '0;
            ovf_reg       <= 1'b0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_reg       <= cmp_next;
            ovf_reg       <= ovf_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output payload
    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        k_reg        <= k_next;
        lo_reg       <= lo_next;
        mid_reg      <= mid_next;
        hi_reg       <= hi_next;
        out_key_reg  <= out_key_next;
        out_tag_reg  <= out_tag_next;
        out_last_reg <= out_last_next;
        out_cmp_reg  <= out_cmp_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // Split stack
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stk_lo_reg[push_idx] <= push_lo;
            stk_hi_reg[push_idx] <= push_hi;
            stk_ph_reg[push_idx] <= PH_LEFT;
        end
        if (ph_we)
        begin
            stk_ph_reg[top_idx] <= ph_val;
        end
    end

    // Record store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            record_store[st_waddr] <= st_wdata;
        end
        rd_a_reg <= record_store[st_raddr_a];
        rd_b_reg <= record_store[st_raddr_b];
    end

    // Merge buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            merge_buffer[buf_waddr] <= buf_wdata;
        end
        buf_rd_reg <= merge_buffer[k_reg[IDX_W-1:0]];
    end

    // Checks
    `SMSR_ASSERT_IMP(a_no_overlap, clk, rst_n, in_ready, !out_valid)
    `SMSR_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CNT_MAX)
    `SMSR_ASSERT_IMP(a_cmp_on_last, clk, rst_n, out_valid && !last_out, compare_count == '0)
    `SMSR_ASSERT_NXT(a_set_done, clk, rst_n, out_valid && out_ready && last_out, in_ready)

endmodule

>>> sim/stable_merge_sort_records_tb.sv
// ----------------------------------------------------------------------------
// stable_merge_sort_records_tb
// Feeds sets of keyed records to the merge sort block and checks that each
// set comes back in stable key order, with the last marker, the overflow
// flag and the comparison count of top-down merge sort. Both handshakes
// idle at random, and one set overruns the store so that records are dropped.
// ----------------------------------------------------------------------------
module stable_merge_sort_records_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smsr_pkg::*;

    localparam int SET_CAP     = 64;
    localparam int KEY_MAX     = (1 << KEY_W) - 1;
    localparam int TAIL_CYCLES = 100;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
    } record_req_t;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
        logic [CMP_W-1:0] count;
        logic             ovf;
    } sorted_rec_t;

    typedef enum int {
        KEYS_FEW,
        KEYS_WIDE,
        KEYS_ENDS
    } key_spread_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             in_valid      = 1'b0;
    logic             in_ready;
    logic [KEY_W-1:0] sort_key      = '0;
    logic [TAG_W-1:0] record_tag    = '0;
    logic             is_last       = 1'b0;
    logic             out_valid;
    logic             out_ready     = 1'b0;
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             last_out;
    logic [CMP_W-1:0] compare_count;
    logic             overflowed;

    stable_merge_sort_records i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sort_key      (sort_key),
        .record_tag    (record_tag),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sorted_key    (sorted_key),
        .sorted_tag    (sorted_tag),
        .last_out      (last_out),
        .compare_count (compare_count),
        .overflowed    (overflowed)
    );

    // Requests waiting for the driver, sorted records waiting for the monitor
    record_req_t pending_requests[$];
    sorted_rec_t expected_sorted[$];

    int fail_count     = 0;
    int accepted_count = 0;

    // Records of the set being collected
    logic [KEY_W-1:0] held_key [SET_CAP];
    logic [TAG_W-1:0] held_tag [SET_CAP];
    logic [KEY_W-1:0] spare_key[SET_CAP];
    logic [TAG_W-1:0] spare_tag[SET_CAP];
    int               held_count    = 0;
    int               compare_total = 0;
    bit               dropped       = 1'b0;

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hold reset low at the start, then release it once
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog
    initial
    begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    // Pick an idle length: mostly short, a few long, none while calm
    function automatic int idle_length(bit calm);
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 45)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Merge held runs [lo..mid] and [mid+1..hi], left first on equal keys
    function automatic void merge_span(int lo, int mid, int hi);
        int a;
        int b;
        int k;
        a = lo;
        b = mid + 1;
        k = lo;
        while (a <= mid && b <= hi)
        begin
            if (compare_total < int'(CMP_SAT))
                compare_total++;
            if (held_key[a] <= held_key[b])
            begin
                spare_key[k] = held_key[a];
                spare_tag[k] = held_tag[a];
                a++;
            end
            else
            begin
                spare_key[k] = held_key[b];
                spare_tag[k] = held_tag[b];
                b++;
            end
            k++;
        end
        while (a <= mid)
        begin
            spare_key[k] = held_key[a];
            spare_tag[k] = held_tag[a];
            a++;
            k++;
        end
        while (b <= hi)
        begin
            spare_key[k] = held_key[b];
            spare_tag[k] = held_tag[b];
            b++;
            k++;
        end
        for (k = lo; k <= hi; k++)
        begin
            held_key[k] = spare_key[k];
            held_tag[k] = spare_tag[k];
        end
    endfunction

    // Top-down sort: list the midpoint splits, then merge children before parents
    function automatic void sort_held(int n);
        int span_lo[$];
        int span_hi[$];
        int plan_lo[$];
        int plan_mid[$];
        int plan_hi[$];
        int lo;
        int hi;
        int mid;
        span_lo.push_back(0);
        span_hi.push_back(n - 1);
        while (span_lo.size() != 0)
        begin
            lo = span_lo.pop_back();
            hi = span_hi.pop_back();
            if (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                plan_lo.push_back(lo);
                plan_mid.push_back(mid);
                plan_hi.push_back(hi);
                span_lo.push_back(lo);
                span_hi.push_back(mid);
                span_lo.push_back(mid + 1);
                span_hi.push_back(hi);
            end
        end
        while (plan_lo.size() != 0)
            merge_span(plan_lo.pop_back(), plan_mid.pop_back(), plan_hi.pop_back());
    endfunction

    // Store one accepted request; on the last one, sort and queue the set
    function automatic void absorb_request(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                                           logic last);
        sorted_rec_t rec;
        int          k;
        if (held_count < SET_CAP)
        begin
            held_key[held_count] = key;
            held_tag[held_count] = tag;
            held_count++;
        end
        else
            dropped = 1'b1;
        if (last)
        begin
            compare_total = 0;
            if (held_count > 1)
                sort_held(held_count);
            for (k = 0; k < held_count; k++)
            begin
                rec.key   = held_key[k];
                rec.tag   = held_tag[k];
                rec.last  = (k == held_count - 1);
                rec.count = rec.last ? compare_total[CMP_W-1:0] : '0;
                rec.ovf   = dropped;
                expected_sorted.push_back(rec);
            end
            held_count    = 0;
            compare_total = 0;
            dropped       = 1'b0;
        end
    endfunction

    function automatic void add_request(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                                        logic last);
        record_req_t req;
        req.key  = key;
        req.tag  = tag;
        req.last = last;
        pending_requests.push_back(req);
    endfunction

    // Queue one set of n records with random tags
    function automatic void queue_set(int n, key_spread_t spread);
        logic [KEY_W-1:0] key;
        int               i;
        for (i = 0; i < n; i++)
        begin
            case (spread)
                KEYS_FEW:  key = KEY_W'($urandom_range(0, 3));
                KEYS_ENDS: key = ($urandom_range(0, 1) != 0) ? KEY_W'(KEY_MAX) : '0;
                default:   key = KEY_W'($urandom());
            endcase
            add_request(key, $urandom(), i == n - 1);
        end
    endfunction

    function automatic int small_set_size();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return $urandom_range(1, 8);
        if (pick < 9)
            return $urandom_range(9, 20);
        return $urandom_range(21, 40);
    endfunction

    function automatic void check_field(string field, logic [TAG_W-1:0] want,
                                        logic [TAG_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    // Driver: present queued requests, with random gaps between them
    int in_gap  = 0;
    bit in_calm = 1'b0;

    always @(posedge clk)
    begin
        record_req_t next_req;
        if (rst_n)
        begin
            // Predict on each accepted request
            if (in_valid && in_ready)
            begin
                absorb_request(sort_key, record_tag, is_last);
                accepted_count++;
                in_gap = idle_length(in_calm);
                if ($urandom_range(0, 39) == 0)
                    in_calm = !in_calm;
            end
            // Advance only when nothing is held waiting
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_req   = pending_requests.pop_front();
                    sort_key   <= next_req.key;
                    record_tag <= next_req.tag;
                    is_last    <= next_req.last;
                    in_valid   <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each taken result with the oldest expected record
    int out_stall = 0;
    bit out_calm  = 1'b0;

    always @(posedge clk)
    begin
        sorted_rec_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_sorted.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual key %h tag %h",
                             $time, sorted_key, sorted_tag);
                    fail_count++;
                end
                else
                begin
                    want = expected_sorted.pop_front();
                    check_field("sorted_key", TAG_W'(want.key), TAG_W'(sorted_key));
                    check_field("sorted_tag", want.tag, sorted_tag);
                    check_field("last_out", TAG_W'(want.last), TAG_W'(last_out));
                    check_field("compare_count", TAG_W'(want.count), TAG_W'(compare_count));
                    check_field("overflowed", TAG_W'(want.ovf), TAG_W'(overflowed));
                end
            end
            // Stall out_ready at random
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    out_stall = idle_length(out_calm);
                if ($urandom_range(0, 99) == 0)
                    out_calm = !out_calm;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int total_requests;
        int i;

        // Lone record at the top key and full tag
        add_request(KEY_W'(KEY_MAX), '1, 1'b1);
        // Equal keys keep arrival order
        add_request(KEY_W'(100), 32'h0000_0001, 1'b0);
        add_request(KEY_W'(100), 32'h0000_0002, 1'b1);
        // Key extremes out of order
        add_request(KEY_W'(KEY_MAX), 32'h0000_0000, 1'b0);
        add_request('0, 32'hFFFF_FFFF, 1'b0);
        add_request(KEY_W'(12'h800), 32'h5A5A_A5A5, 1'b1);
        // Descending pairs of ties
        for (i = 0; i < 8; i++)
            add_request(KEY_W'(KEY_MAX - (i / 2) * 500), 32'h0000_1000 + i, i == 7);
        // Already ascending
        for (i = 0; i < 6; i++)
            add_request(KEY_W'(i * 3), 32'h0000_2000 + i, i == 5);

        // Random sets, one full store, one that overruns it including the last record
        while (pending_requests.size() < 90)
            queue_set(small_set_size(), key_spread_t'($urandom_range(0, 2)));
        queue_set(SET_CAP, KEYS_WIDE);
        while (pending_requests.size() < 140)
            queue_set(small_set_size(), key_spread_t'($urandom_range(0, 2)));
        queue_set(SET_CAP + 3, KEYS_FEW);
        while (pending_requests.size() < 220)
            queue_set(small_set_size(), key_spread_t'($urandom_range(0, 2)));
        total_requests = pending_requests.size();

        // Drain
        while (accepted_count != total_requests)
            @(posedge clk);
        while (expected_sorted.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_sorted.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/smsr_pkg.sv
rtl/core/stable_merge_sort_records.sv
sim/stable_merge_sort_records_tb.sv
